[hw/rtl/posit8_dyadic_encoder_core_macros.svh]
// assertion macros for the posit encoder core
// no dependencies; included by the files that carry assertions
`ifndef POSIT8_DYADIC_ENCODER_CORE_MACROS_SVH
`define POSIT8_DYADIC_ENCODER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define P8DE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p8de assertion failed");

// antecedent implies consequent in the next cycle
`define P8DE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p8de assertion failed");

`endif

[hw/rtl/p8de_pkg.sv]
// shared constants for the posit encoder core
// no dependencies
`timescale 1ns / 1ps

package p8de_pkg;

	localparam int DEFAULT_POSIT_WIDTH = 8;
	localparam int NUM_W = 32;
	localparam int EXP_W = 8;
	localparam int LEAD_W = $clog2(NUM_W);
	localparam logic signed [EXP_W-1:0] SCALE_EXP_RESET = -8'sd32;

endpackage

[hw/rtl/p8de_encode.sv]
// combinational posit encode: leading one, regime split, pack and round
// depends on p8de_pkg
`timescale 1ns / 1ps

module p8de_encode #(
	parameter int POSIT_WIDTH = p8de_pkg::DEFAULT_POSIT_WIDTH
) (
	input  logic [p8de_pkg::NUM_W-1:0]        numerator,
	input  logic signed [p8de_pkg::EXP_W-1:0] scale_exponent,
	output logic [POSIT_WIDTH-2:0]            posit_pattern
);
	import p8de_pkg::*;

	localparam int PW = POSIT_WIDTH - 1;
	localparam int RW = PW;
	localparam int BODY_W = NUM_W + 1;
	localparam int EXT_W = RW + BODY_W;
	localparam int SHW = $clog2(RW + 1);
	localparam int X_W = EXP_W + 2;
	localparam logic signed [X_W-1:0] R_MAX = X_W'(POSIT_WIDTH - 2);
	localparam logic signed [X_W-1:0] R_MIN = X_W'(1 - POSIT_WIDTH);

	logic [LEAD_W-1:0]       lead;
	logic [NUM_W-1:0]        norm;
	logic signed [X_W-1:0]   x;
	logic signed [X_W-1:0]   r;
	logic signed [X_W-1:0]   run_x;
	logic signed [X_W-1:0]   regwid_x;
	logic [SHW-1:0]          run;
	logic [SHW-1:0]          regwid;
	logic [1:0]              elo;
	logic                    neg;
	logic                    too_big;
	logic                    too_small;
	logic [RW-1:0]           reg_field;
	logic [BODY_W-1:0]       body;
	logic [EXT_W-1:0]        ext;
	logic [PW-1:0]           keep;
	logic                    guard;
	logic                    sticky;
	logic                    round_up;

	// leading one position
	always_comb begin
		lead = '0;
		for (int i = 0; i < NUM_W; i++) begin
			if (numerator[i]) begin
				lead = LEAD_W'(i);
			end
		end
	end

	assign norm = numerator << (LEAD_W'(NUM_W - 1) - lead);
	assign x = signed'(X_W'(scale_exponent)) + signed'(X_W'({1'b0, lead}));
	assign r = x >>> 2;
	assign elo = x[1:0];
	assign neg = r[X_W-1];
	assign too_big = r >= R_MAX;
	assign too_small = r <= R_MIN;

	assign run_x = neg ? -r : r + X_W'(1);
	assign regwid_x = neg ? X_W'(1) - r : r + X_W'(2);
	assign run = run_x[SHW-1:0];
	assign regwid = regwid_x[SHW-1:0];

	// regime field left aligned
	always_comb begin
		if (neg) begin
			reg_field = {1'b1, {(RW-1){1'b0}}} >> run;
		end else begin
			reg_field = ~({RW{1'b1}} >> run);
		end
	end

	assign body = {elo, norm[NUM_W-2:0]};
	assign ext = {reg_field, BODY_W'(0)} | ({body, RW'(0)} >> regwid);
	assign keep = ext[EXT_W-1 -: PW];
	assign guard = ext[EXT_W-1-PW];
	assign sticky = |ext[EXT_W-2-PW:0];
	assign round_up = guard & (sticky | keep[0]);

	always_comb begin
		if (numerator == '0) begin
			posit_pattern = '0;
		end else if (too_big) begin
			posit_pattern = '1;
		end else if (too_small) begin
			posit_pattern = PW'(1);
		end else if (round_up && (&keep)) begin
			posit_pattern = '1;
		end else begin
			posit_pattern = keep + PW'(round_up);
		end
	end

endmodule

[hw/rtl/posit8_dyadic_encoder_core.sv]
// an accepted item is captured in the input register, then in the result register, which presents it
// throughput: one item per cycle while the result is not stalled; input register, encode logic, result register
// a stalled result holds the pipe while the input register is full
// reset: arst_n asynchronous active low, clears valids, scale_exponent to -32
// depends on p8de_pkg, p8de_encode and posit8_dyadic_encoder_core_macros.svh
`timescale 1ns / 1ps

`include "posit8_dyadic_encoder_core_macros.svh"

module posit8_dyadic_encoder_core #(
	parameter int POSIT_WIDTH = p8de_pkg::DEFAULT_POSIT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [p8de_pkg::EXP_W-1:0]        cfg_wdata,
	input  logic                              numerator_valid,
	output logic                              numerator_stall,
	input  logic [p8de_pkg::NUM_W-1:0]        numerator,
	output logic                              posit_valid,
	input  logic                              posit_stall,
	output logic [POSIT_WIDTH-2:0]            posit_pattern
);
	import p8de_pkg::*;

	logic signed [EXP_W-1:0] scale_exponent_q;
	logic [NUM_W-1:0]        numerator_s1;
	logic                    valid_s1;
	logic [POSIT_WIDTH-2:0]  pattern_s2;
	logic                    valid_s2;
	logic [POSIT_WIDTH-2:0]  pattern_comb;
	logic                    adv_out;

	assign adv_out = !valid_s2 || !posit_stall;
	assign numerator_stall = valid_s1 && !adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_exponent_q <= SCALE_EXP_RESET;
		end else if (cfg_we) begin
			scale_exponent_q <= signed'(cfg_wdata);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!numerator_stall) begin
			valid_s1 <= numerator_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (numerator_valid && !numerator_stall) begin
			numerator_s1 <= numerator;
		end
	end

	p8de_encode #(
		.POSIT_WIDTH(POSIT_WIDTH)
	) u_encode (
		.numerator(numerator_s1),
		.scale_exponent(scale_exponent_q),
		.posit_pattern(pattern_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_out) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_out) begin
			pattern_s2 <= pattern_comb;
		end
	end

	assign posit_valid = valid_s2;
	assign posit_pattern = pattern_s2;

	`P8DE_ASSERT_SAME(a_stall_needs_item, clk, arst_n, numerator_stall, valid_s1)
	`P8DE_ASSERT_SAME(a_full_blocked_stalls, clk, arst_n, valid_s1 && valid_s2 && posit_stall, numerator_stall)
	`P8DE_ASSERT_NEXT(a_zero_encodes_zero, clk, arst_n, valid_s1 && adv_out && numerator_s1 == '0, posit_pattern == '0)
	`P8DE_ASSERT_NEXT(a_nonzero_stays_nonzero, clk, arst_n, valid_s1 && adv_out && numerator_s1 != '0, posit_pattern != '0)
	`P8DE_ASSERT_SAME(a_result_from_input_reg, clk, arst_n, $rose(valid_s2), $past(valid_s1))

endmodule
